### rtl/core/fem_pkg.sv
// ----------------------------------------------------------------------------
// fem_pkg
// Shared types, constants and helpers for the fog edge map shader.
// ----------------------------------------------------------------------------
package fem_pkg;

  // Map geometry
  localparam int MAX_SIDE     = 1024;
  localparam int DEFAULT_SIDE = 512;
  localparam int CFG_W        = 11;
  localparam int SIDE_W       = $clog2(MAX_SIDE + 1);  // holds 1..MAX_SIDE
  localparam int EXT_W        = SIDE_W + 1;            // compare width
  localparam int COL_W        = $clog2(MAX_SIDE);      // column / pixel index
  localparam int ROW_W        = $clog2(MAX_SIDE + 2);  // input row runs to side+1

  // Pixel constants
  localparam logic [7:0] PIX_MAX       = 8'd255;
  localparam logic [7:0] EMPTY_RG      = 8'd10;
  localparam logic [7:0] EMPTY_B       = 8'd15;
  localparam logic [7:0] EMPTY_EDGE_RG = 8'd5;
  localparam logic [7:0] EMPTY_EDGE_B  = 8'd7;

  typedef enum logic {
    OP_CELL  = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  typedef struct packed {
    logic       revealed;
    logic       empty;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } cell_t;

  // Line buffer word at one column: revealed bit two rows back, cell one row back
  typedef struct packed {
    logic  rev_up;
    cell_t cdata;
  } line_word_t;

  // Item held between the sequencer and the shading stage
  typedef struct packed {
    logic             vld;
    logic             emit;
    logic             border;
    logic             last;
    logic             use_last;
    logic [COL_W-1:0] col;
    cell_t            cdata;
  } s1_t;

  // Effective side: zero means default, clamp at MAX_SIDE
  function automatic logic [SIDE_W-1:0] side_eff(input logic [CFG_W-1:0] cfg);
    logic [SIDE_W-1:0] s;
    if (cfg == '0) begin
      s = SIDE_W'(DEFAULT_SIDE);
    end else if (int'(cfg) > MAX_SIDE) begin
      s = SIDE_W'(MAX_SIDE);
    end else begin
      s = SIDE_W'(cfg);
    end
    return s;
  endfunction

  // min(255, 8c), or min(255, 4c) on an edge
  function automatic logic [7:0] shade_chan(input logic [7:0] c, input logic on_edge);
    logic [7:0] v;
    if (on_edge) begin
      v = (c[7:6] != 2'b00) ? PIX_MAX : {c[5:0], 2'b00};
    end else begin
      v = (c[7:5] != 3'b000) ? PIX_MAX : {c[4:0], 3'b000};
    end
    return v;
  endfunction

endpackage

### rtl/core/fem_ram.sv
// ----------------------------------------------------------------------------
// fem_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module fem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/fem_seq.sv
// ----------------------------------------------------------------------------
// fem_seq
// Input sequencer: map size register, raster counters, line buffer read and
// the stage register that feeds the shading stage.
// ----------------------------------------------------------------------------
module fem_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [fem_pkg::CFG_W-1:0]  cfg_map_side,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_opcode,
  input  logic                       in_cell_revealed,
  input  logic                       in_cell_empty,
  input  logic [7:0]                 in_color_red,
  input  logic [7:0]                 in_color_green,
  input  logic [7:0]                 in_color_blue,
  input  logic                       s1_adv,
  output fem_pkg::s1_t               s1,
  output logic                       ram_re,
  output logic [fem_pkg::COL_W-1:0]  ram_raddr
);
  import fem_pkg::*;

  logic [CFG_W-1:0]  map_side_r, map_side_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  pc_r, pc_nxt;
  logic [COL_W-1:0]  pr_r, pr_nxt;
  cell_t             last_cell_r, last_cell_nxt;
  s1_t               s1_r, s1_nxt;

  op_t               op;
  logic [SIDE_W-1:0] side, side_m1;
  logic              in_fire, cell_go, flush_go, go, emit0;
  logic              side_one, pc_end, pr_end, col_end, border0, last0;
  cell_t             new_cell;

  assign op = op_t'(in_opcode);

  always_comb begin
    side     = side_eff(map_side_r);
    side_m1  = side - SIDE_W'(1);
    side_one = (side == SIDE_W'(1));
    in_ready = !s1_r.vld || s1_adv;
    in_fire  = in_valid && in_ready;
    cell_go  = (op == OP_CELL) && (row_r < ROW_W'(side));
    flush_go = (op == OP_FLUSH) && !(row_r < ROW_W'(side));
    go       = in_fire && (cell_go || flush_go);
    // a cell is shaded once one row and one cell behind it have arrived
    emit0    = flush_go ||
               (cell_go && ((row_r >= ROW_W'(2)) || ((row_r == ROW_W'(1)) && (col_r != '0))));
    pc_end   = (EXT_W'(pc_r) == EXT_W'(side_m1));
    pr_end   = (EXT_W'(pr_r) == EXT_W'(side_m1));
    col_end  = ((EXT_W'(col_r) + EXT_W'(1)) == EXT_W'(side));
    border0  = (pr_r == '0) || pr_end || (pc_r == '0) || pc_end;
    last0    = pr_end && pc_end;

    new_cell.revealed = in_cell_revealed;
    new_cell.empty    = in_cell_empty;
    new_cell.red      = in_color_red;
    new_cell.green    = in_color_green;
    new_cell.blue     = in_color_blue;

    map_side_nxt  = map_side_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    pc_nxt        = pc_r;
    pr_nxt        = pr_r;
    last_cell_nxt = last_cell_r;

    if (go) begin
      // flush ticks keep the raster moving with unrevealed virtual cells
      col_nxt = col_end ? '0 : col_r + COL_W'(1);
      if (col_end) begin
        row_nxt = row_r + ROW_W'(1);
      end
      if (emit0) begin
        if (pc_end) begin
          pc_nxt = '0;
          pr_nxt = pr_r + COL_W'(1);
        end else begin
          pc_nxt = pc_r + COL_W'(1);
        end
        if (last0) begin
          col_nxt = '0;
          row_nxt = '0;
          pc_nxt  = '0;
          pr_nxt  = '0;
        end
      end
    end
    if (in_fire && cell_go) begin
      last_cell_nxt = new_cell;
    end
    if (cfg_valid) begin
      map_side_nxt = cfg_map_side;
      col_nxt      = '0;
      row_nxt      = '0;
      pc_nxt       = '0;
      pr_nxt       = '0;
    end

    s1_nxt = s1_r;
    if (go) begin
      s1_nxt.vld      = 1'b1;
      s1_nxt.emit     = emit0;
      s1_nxt.border   = border0;
      s1_nxt.last     = emit0 && last0;
      // one-cell map: the only pixel comes from the held cell
      s1_nxt.use_last = flush_go && side_one;
      s1_nxt.col      = col_r;
      if (flush_go) begin
        s1_nxt.cdata = side_one ? last_cell_r : '0;
      end else begin
        s1_nxt.cdata = new_cell;
      end
    end else if (s1_adv) begin
      s1_nxt.vld = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_side_r <= CFG_W'(DEFAULT_SIDE);
      col_r      <= '0;
      row_r      <= '0;
      pc_r       <= '0;
      pr_r       <= '0;
      s1_r       <= '0;
    end else begin
      map_side_r <= map_side_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      pc_r       <= pc_nxt;
      pr_r       <= pr_nxt;
      s1_r       <= s1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_cell_r <= last_cell_nxt;
  end

  assign cfg_ready = 1'b1;
  assign s1        = s1_r;
  assign ram_re    = go;
  assign ram_raddr = col_r;

  a_last_on_border: assert property (@(posedge clk) disable iff (!rst_n)
    s1_r.vld && s1_r.last |-> s1_r.emit && s1_r.border)
    else $error("frame end pixel not flagged as border");

  a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    go && emit0 && last0 |=> (row_r == '0) && (col_r == '0) && (pc_r == '0) && (pr_r == '0))
    else $error("counters not cleared after frame end");

  a_read_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |=> s1_r.vld)
    else $error("line read without stage load");

endmodule

### rtl/core/fem_shade.sv
// ----------------------------------------------------------------------------
// fem_shade
// Shading stage: 3x3 revealed window, edge test, color shading and the
// output register.
// ----------------------------------------------------------------------------
module fem_shade (
  input  logic                       clk,
  input  logic                       rst_n,
  input  fem_pkg::s1_t               s1,
  input  fem_pkg::line_word_t        rd,
  output logic                       s1_adv,
  output logic                       ram_we,
  output logic [fem_pkg::COL_W-1:0]  ram_waddr,
  output fem_pkg::line_word_t        ram_wdata,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_pixel_red,
  output logic [7:0]                 out_pixel_green,
  output logic [7:0]                 out_pixel_blue,
  output logic                       out_frame_last
);
  import fem_pkg::*;

  // window columns: [2] row above, [1] center row, [0] row below
  logic [2:0] win1_r, win1_nxt, win2_r, win2_nxt, win0;
  cell_t      mid_cell_r, mid_cell_nxt, center;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] red_r, green_r, blue_r, red_nxt, green_nxt, blue_nxt;
  logic       last_r, last_nxt;
  logic       out_load, s1_fire, on_edge, all_rev;

  always_comb begin
    out_load = !out_valid_r || out_ready;
    s1_adv   = !s1.emit || out_load;
    s1_fire  = s1.vld && s1_adv;

    win0    = {rd.rev_up, rd.cdata.revealed, s1.cdata.revealed};
    all_rev = (&win0) && (&win2_r) && win1_r[2] && win1_r[0];
    on_edge = s1.border || !all_rev;
    center  = s1.use_last ? s1.cdata : mid_cell_r;

    red_nxt   = '0;
    green_nxt = '0;
    blue_nxt  = '0;
    if (center.revealed) begin
      if (!center.empty) begin
        red_nxt   = shade_chan(center.red, on_edge);
        green_nxt = shade_chan(center.green, on_edge);
        blue_nxt  = shade_chan(center.blue, on_edge);
      end else if (on_edge) begin
        red_nxt   = EMPTY_EDGE_RG;
        green_nxt = EMPTY_EDGE_RG;
        blue_nxt  = EMPTY_EDGE_B;
      end else begin
        red_nxt   = EMPTY_RG;
        green_nxt = EMPTY_RG;
        blue_nxt  = EMPTY_B;
      end
    end
    last_nxt = s1.last;

    win1_nxt     = win1_r;
    win2_nxt     = win2_r;
    mid_cell_nxt = mid_cell_r;
    if (s1_fire) begin
      win2_nxt     = win1_r;
      win1_nxt     = win0;
      mid_cell_nxt = rd.cdata;
    end

    out_valid_nxt = out_valid_r;
    if (s1_fire && s1.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    ram_we           = s1_fire;
    ram_waddr        = s1.col;
    ram_wdata.rev_up = rd.cdata.revealed;
    ram_wdata.cdata  = s1.cdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win1_r     <= win1_nxt;
    win2_r     <= win2_nxt;
    mid_cell_r <= mid_cell_nxt;
    if (s1_fire && s1.emit) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      last_r  <= last_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_red   = red_r;
  assign out_pixel_green = green_r;
  assign out_pixel_blue  = blue_r;
  assign out_frame_last  = last_r;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    s1.vld && !s1_adv |-> out_valid_r && !out_ready)
    else $error("shading stage stalled with room at output");

  a_emit_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1.emit |=> out_valid_r)
    else $error("shaded pixel lost");

endmodule

### rtl/core/fog_edge_map_shader_core.sv
// ----------------------------------------------------------------------------
// fog_edge_map_shader_core
// Streaming fog-of-war map shader: one shaded pixel per map cell, delayed
// by one map row plus one cell, with edge darkening around unrevealed cells.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------
//  cfg      | cfg_valid/cfg_ready  | cfg_map_side (11b, side of square map)
//  in       | in_valid/in_ready    | in_opcode, in_cell_revealed, in_cell_empty,
//           |                      | in_color_red/green/blue
//  out      | out_valid/out_ready  | out_pixel_red/green/blue, out_frame_last
//
//  One transaction per clock in steady state while the output is ready. A
//  pixel leaves after its releasing transaction loads the stage register
//  and the line buffer read, then is shaded into the output register.
//  Synchronous active-low reset; the line buffer needs no clearing pass,
//  since every neighbor read outside the current frame falls on the map
//  border and is masked by position.
//  A stalled output holds only the shading stage; an input transaction is
//  still taken while the stage register is free.
//
//  Structure: fem_seq counts the raster and reads the line buffer at the
//  incoming column; the line buffer (one word per column) returns the
//  revealed bit two rows back and the cell one row back; fem_shade keeps
//  a 3x3 revealed window, decides edge and shades the center cell.
//  Flush ticks advance the raster with unrevealed virtual cells to drain
//  the last row plus one cell of the frame.
// ----------------------------------------------------------------------------
module fog_edge_map_shader_core (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [fem_pkg::CFG_W-1:0]  cfg_map_side,
  // map cells
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_opcode,
  input  logic                       in_cell_revealed,
  input  logic                       in_cell_empty,
  input  logic [7:0]                 in_color_red,
  input  logic [7:0]                 in_color_green,
  input  logic [7:0]                 in_color_blue,
  // shaded pixels
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_pixel_red,
  output logic [7:0]                 out_pixel_green,
  output logic [7:0]                 out_pixel_blue,
  output logic                       out_frame_last
);
  import fem_pkg::*;

  localparam int LW_W = $bits(line_word_t);

  s1_t               s1;
  logic              s1_adv;
  logic              ram_re, ram_we;
  logic [COL_W-1:0]  ram_raddr, ram_waddr;
  line_word_t        ram_wdata, ram_rd;
  logic [LW_W-1:0]   ram_rdata;

  fem_seq u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_map_side     (cfg_map_side),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_cell_revealed (in_cell_revealed),
    .in_cell_empty    (in_cell_empty),
    .in_color_red     (in_color_red),
    .in_color_green   (in_color_green),
    .in_color_blue    (in_color_blue),
    .s1_adv           (s1_adv),
    .s1               (s1),
    .ram_re           (ram_re),
    .ram_raddr        (ram_raddr)
  );

  // Line buffer: one word per column, read-old at the incoming column
  fem_ram #(
    .WIDTH (LW_W),
    .DEPTH (MAX_SIDE)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_rd = ram_rdata;

  fem_shade u_shade (
    .clk             (clk),
    .rst_n           (rst_n),
    .s1              (s1),
    .rd              (ram_rd),
    .s1_adv          (s1_adv),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_red   (out_pixel_red),
    .out_pixel_green (out_pixel_green),
    .out_pixel_blue  (out_pixel_blue),
    .out_frame_last  (out_frame_last)
  );

endmodule
